// File: src/eia_pkg.sv
// ----------------------------------------------------------------------------
// Entity ID allocator package
// Shared constants, codes, payload structs and state type of the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eia_pkg;

  localparam int unsigned EntitySlots = 256;

  localparam int unsigned IdFieldW  = 8;
  localparam int unsigned KindW     = 2;
  localparam int unsigned LimitW    = 9;
  localparam int unsigned CfgIdxW   = 4;

  localparam logic [LimitW-1:0] LimitReset = 9'd256;

  localparam logic [CfgIdxW-1:0] CFG_AGENT_LIMIT     = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_ATTRACTOR_LIMIT = 4'd1;

  localparam logic OP_SPAWN   = 1'b0;
  localparam logic OP_DESTROY = 1'b1;

  typedef struct packed {
    logic                op;
    logic [IdFieldW-1:0] entity_id;
    logic [KindW-1:0]    kind;
  } eia_in_t;

  typedef struct packed {
    logic                ok;
    logic [IdFieldW-1:0] value;
  } eia_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_WR1,
    ST_WR2
  } eia_state_e;

endpackage

`default_nettype wire

// File: src/eia_ram.sv
// ----------------------------------------------------------------------------
// Single-port RAM
// Generic synchronous RAM with one read/write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eia_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/entity_id_allocator.sv
// ----------------------------------------------------------------------------
// Entity ID allocator
// Hands out entity identifiers from a free stack and keeps live ones in a
// packed list with an identifier-to-position map.
// ----------------------------------------------------------------------------
// Usage: an input word carries an operation (spawn or destroy), an entity
// identifier and kind bits; it is taken when in_valid_i is high and
// in_stall_o is low. Every input word yields exactly one output word with an
// ok flag and a value, offered on out_valid_o and held while out_stall_i is
// high. The user writes the limits over the configuration channel while the
// block is idle (not enforced by the block); cfg_ready_o is always high.
// A spawn result or a refused destroy is registered from ST_WR1 and a
// successful destroy from ST_WR2; one word is in work at a time, bounded
// by the read-modify-write sequence on the single-port position map and
// slot memory. The input is taken again in the cycle after the result is
// registered. After reset the block runs an initialisation pass over all
// EntitySlots entries that clears the position map and fills the free
// stack; in_stall_o is high during this pass. While a finished result is
// stalled the block holds its last step and completes once the output
// register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module entity_id_allocator #(
  parameter int unsigned EntitySlots = eia_pkg::EntitySlots
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire eia_pkg::eia_in_t             in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output eia_pkg::eia_out_t                 out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [eia_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [eia_pkg::LimitW-1:0]   cfg_data_i
);

  localparam int unsigned IdW  = $clog2(EntitySlots);
  localparam int unsigned CntW = $clog2(EntitySlots + 1);
  localparam int unsigned CmpW = (CntW > eia_pkg::LimitW) ? CntW : eia_pkg::LimitW;

  eia_pkg::eia_state_e state_q, state_d;

  logic [IdW-1:0]             clr_q;
  logic [CntW-1:0]            live_q, live_d;
  logic [CntW-1:0]            agent_cnt_q, agent_cnt_d;
  logic [CntW-1:0]            attr_cnt_q, attr_cnt_d;
  logic [eia_pkg::LimitW-1:0] agent_lim_q, attr_lim_q;

  logic                       op_q;
  logic [eia_pkg::KindW-1:0]  kind_q;
  logic [IdW-1:0]             id_q;
  logic                       id_ok_q;
  logic                       mvalid_q;
  logic [IdW-1:0]             mpos_q;
  logic [IdW-1:0]             slot_q;

  logic                       out_valid_q;
  eia_pkg::eia_out_t          out_data_q;

  logic                       in_acc, out_free, fin;
  eia_pkg::eia_out_t          res;

  logic                       map_we;
  logic [IdW-1:0]             map_addr;
  logic [IdW:0]               map_wdata, map_rdata;
  logic                       slot_we;
  logic [IdW-1:0]             slot_addr, slot_wdata, slot_rdata;

  logic [CntW-1:0]            live_dec;
  logic                       add_a, add_t, del_a, del_t;
  logic                       spawn_ok, dest_ok;

  assign in_stall_o  = (state_q != eia_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign live_dec = live_q - CntW'(1);

  assign add_a = kind_q[0] && (CmpW'(agent_cnt_q) < CmpW'(agent_lim_q));
  assign add_t = kind_q[1] && (CmpW'(attr_cnt_q) < CmpW'(attr_lim_q));
  assign del_a = kind_q[0] && (agent_cnt_q != '0);
  assign del_t = kind_q[1] && (attr_cnt_q != '0);

  assign spawn_ok = (add_a || add_t) && (live_q != CntW'(EntitySlots));
  assign dest_ok  = (del_a || del_t) && id_ok_q && mvalid_q && (live_q != '0)
                    && (CntW'(mpos_q) < live_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      eia_pkg::ST_CLEAR: begin
        if (clr_q == IdW'(EntitySlots - 1)) begin
          state_d = eia_pkg::ST_IDLE;
        end
      end
      eia_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = eia_pkg::ST_EVAL;
        end
      end
      eia_pkg::ST_EVAL: begin
        state_d = eia_pkg::ST_WR1;
      end
      eia_pkg::ST_WR1: begin
        if (op_q == eia_pkg::OP_DESTROY && dest_ok) begin
          state_d = eia_pkg::ST_WR2;
        end else if (out_free) begin
          state_d = eia_pkg::ST_IDLE;
        end
      end
      eia_pkg::ST_WR2: begin
        if (out_free) begin
          state_d = eia_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = eia_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    map_we      = 1'b0;
    map_addr    = IdW'(in_data_i.entity_id);
    map_wdata   = '0;
    slot_we     = 1'b0;
    slot_addr   = (in_data_i.op == eia_pkg::OP_SPAWN) ? live_q[IdW-1:0] : live_dec[IdW-1:0];
    slot_wdata  = slot_q;
    fin         = 1'b0;
    res.ok      = 1'b0;
    res.value   = '0;
    live_d      = live_q;
    agent_cnt_d = agent_cnt_q;
    attr_cnt_d  = attr_cnt_q;
    case (state_q)
      eia_pkg::ST_CLEAR: begin
        map_we     = 1'b1;
        map_addr   = clr_q;
        slot_we    = 1'b1;
        slot_addr  = clr_q;
        slot_wdata = clr_q;
      end
      eia_pkg::ST_WR1: begin
        if (op_q == eia_pkg::OP_SPAWN) begin
          map_we    = spawn_ok;
          map_addr  = slot_q;
          map_wdata = {1'b1, live_q[IdW-1:0]};
          fin       = out_free;
          res.ok    = spawn_ok;
          res.value = spawn_ok ? eia_pkg::IdFieldW'(slot_q) : '0;
          if (spawn_ok) begin
            live_d      = live_q + CntW'(1);
            agent_cnt_d = agent_cnt_q + CntW'(add_a);
            attr_cnt_d  = attr_cnt_q + CntW'(add_t);
          end
        end else if (dest_ok) begin
          map_we     = 1'b1;
          map_addr   = slot_q;
          map_wdata  = {1'b1, mpos_q};
          slot_we    = 1'b1;
          slot_addr  = mpos_q;
          slot_wdata = slot_q;
        end else begin
          fin = out_free;
        end
      end
      eia_pkg::ST_WR2: begin
        map_we      = 1'b1;
        map_addr    = id_q;
        map_wdata   = '0;
        slot_we     = 1'b1;
        slot_addr   = live_dec[IdW-1:0];
        slot_wdata  = id_q;
        fin         = out_free;
        res.ok      = 1'b1;
        res.value   = eia_pkg::IdFieldW'(mpos_q);
        live_d      = live_dec;
        agent_cnt_d = agent_cnt_q - CntW'(del_a);
        attr_cnt_d  = attr_cnt_q - CntW'(del_t);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eia_pkg::ST_CLEAR;
      clr_q       <= '0;
      live_q      <= '0;
      agent_cnt_q <= '0;
      attr_cnt_q  <= '0;
      agent_lim_q <= eia_pkg::LimitReset;
      attr_lim_q  <= eia_pkg::LimitReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == eia_pkg::ST_CLEAR) begin
        clr_q <= clr_q + IdW'(1);
      end
      if (fin) begin
        live_q      <= live_d;
        agent_cnt_q <= agent_cnt_d;
        attr_cnt_q  <= attr_cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          eia_pkg::CFG_AGENT_LIMIT:     agent_lim_q <= cfg_data_i;
          eia_pkg::CFG_ATTRACTOR_LIMIT: attr_lim_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= in_data_i.op;
      kind_q  <= in_data_i.kind;
      id_q    <= IdW'(in_data_i.entity_id);
      id_ok_q <= (32'(in_data_i.entity_id) < EntitySlots);
    end
    if (state_q == eia_pkg::ST_EVAL) begin
      mvalid_q <= map_rdata[IdW];
      mpos_q   <= map_rdata[IdW-1:0];
      slot_q   <= slot_rdata;
    end
    if (fin) begin
      out_data_q <= res;
    end
  end

  eia_ram #(
    .Width (IdW + 1),
    .Depth (EntitySlots)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .addr_i  (map_addr),
    .wdata_i (map_wdata),
    .rdata_o (map_rdata)
  );

  eia_ram #(
    .Width (IdW),
    .Depth (EntitySlots)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .addr_i  (slot_addr),
    .wdata_i (slot_wdata),
    .rdata_o (slot_rdata)
  );

endmodule

`default_nettype wire

// File: src/eia_checker.sv
// ----------------------------------------------------------------------------
// Entity ID allocator checker
// Port-level assertions on the allocator, attached to it by a bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eia_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire eia_pkg::eia_out_t out_data_o
);

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled output word changed or was dropped.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("Input taken again straight after an accepted word.");

  a_refusal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.value == '0)
    else $error("Refused operation carries a non-zero value.");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Result appeared while the block was idle.");

endmodule

bind entity_id_allocator eia_checker u_eia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// File: tb/entity_id_allocator_tb.sv
// ----------------------------------------------------------------------------
// Entity ID allocator testbench
// Drives spawn and destroy words into the allocator under randomised gaps and
// output stalls, and compares every result word with a cycle-free model of
// the free stack, the packed live list and the kind counters. Limits are
// changed between phases while the block is idle, and one long output stall
// makes the block back up onto its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module entity_id_allocator_tb;
  import eia_pkg::*;

  localparam logic [KindW-1:0] KIND_NONE      = 2'b00;
  localparam logic [KindW-1:0] KIND_AGENT     = 2'b01;
  localparam logic [KindW-1:0] KIND_ATTRACTOR = 2'b10;
  localparam logic [KindW-1:0] KIND_BOTH      = 2'b11;

  localparam int CycleLimit   = 400000;
  localparam int DrainLimit   = 2000;
  localparam int SettleCycles = 8;
  localparam int LongHold     = 400;
  localparam int MaxReports   = 10;

  localparam int NumPhases = 6;
  localparam int PhaseAgentCap     [NumPhases] = '{256, 511, 0, 3, 1, 256};
  localparam int PhaseAttractorCap [NumPhases] = '{256, 1, 256, 2, 0, 511};
  localparam int PhaseItems        [NumPhases] = '{400, 250, 200, 200, 150, 300};
  localparam int PhaseSpawnPct     [NumPhases] = '{97, 20, 60, 50, 50, 75};

  class alloc_scoreboard;
    logic [IdFieldW-1:0] free_ids   [EntitySlots];
    logic [IdFieldW-1:0] packed_ids [EntitySlots];
    logic [KindW-1:0]    born_kind  [EntitySlots];
    bit                  is_live    [EntitySlots];
    int unsigned         slot_of    [EntitySlots];
    int unsigned         free_top;
    int unsigned         live_total;
    int unsigned         agents;
    int unsigned         attractors;
    int unsigned         agent_cap;
    int unsigned         attractor_cap;
    eia_out_t            awaited [$];
    int                  failures;

    function new();
      for (int i = 0; i < EntitySlots; i++) begin
        free_ids[i]   = IdFieldW'(EntitySlots - 1 - i);
        packed_ids[i] = '0;
        born_kind[i]  = KIND_NONE;
        is_live[i]    = 1'b0;
        slot_of[i]    = 0;
      end
      free_top      = EntitySlots;
      live_total    = 0;
      agents        = 0;
      attractors    = 0;
      agent_cap     = LimitReset;
      attractor_cap = LimitReset;
      failures      = 0;
    endfunction

    function void set_limit(logic [CfgIdxW-1:0] idx, logic [LimitW-1:0] data);
      if (idx == CFG_AGENT_LIMIT) begin
        agent_cap = data;
      end else if (idx == CFG_ATTRACTOR_LIMIT) begin
        attractor_cap = data;
      end
    endfunction

    function void note_word(eia_in_t w);
      eia_out_t    res;
      bit          use_a;
      bit          use_t;
      int unsigned id;
      int unsigned pos;
      int unsigned last;
      res = '0;
      id  = w.entity_id;
      if (w.op == OP_SPAWN) begin
        use_a = w.kind[0] && (agents < agent_cap);
        use_t = w.kind[1] && (attractors < attractor_cap);
        if ((use_a || use_t) && free_top != 0 && live_total < EntitySlots) begin
          agents     += use_a;
          attractors += use_t;
          free_top--;
          id = free_ids[free_top];
          packed_ids[live_total] = IdFieldW'(id);
          slot_of[id]   = live_total;
          is_live[id]   = 1'b1;
          born_kind[id] = {use_t, use_a};
          live_total++;
          res.ok    = 1'b1;
          res.value = IdFieldW'(id);
        end
      end else begin
        use_a = w.kind[0] && (agents != 0);
        use_t = w.kind[1] && (attractors != 0);
        if ((use_a || use_t) && is_live[id] && live_total != 0
            && slot_of[id] < live_total) begin
          pos = slot_of[id];
          agents     -= use_a;
          attractors -= use_t;
          last = packed_ids[live_total - 1];
          slot_of[last]   = pos;
          is_live[id]     = 1'b0;
          slot_of[id]     = 0;
          packed_ids[pos] = IdFieldW'(last);
          live_total--;
          if (free_top < EntitySlots) begin
            free_ids[free_top] = IdFieldW'(id);
            free_top++;
          end
          res.ok    = 1'b1;
          res.value = IdFieldW'(pos);
        end
      end
      awaited = {awaited, res};
    endfunction

    function void flag(string what, eia_out_t want, eia_out_t got);
      failures++;
      if (failures <= MaxReports) begin
        $display("%s: expected ok=%0b value=%0d, got ok=%0b value=%0d",
                 what, want.ok, want.value, got.ok, got.value);
      end
    endfunction

    function void check_word(eia_out_t got);
      eia_out_t want;
      if (awaited.size() == 0) begin
        flag("result with none due", '0, got);
        return;
      end
      want = awaited.pop_front();
      if (got.ok !== want.ok || got.value !== want.value) begin
        flag("result mismatch", want, got);
      end
    endfunction

    function void flush_missing();
      while (awaited.size() != 0) begin
        flag("result never arrived", awaited.pop_front(), '0);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  eia_in_t             in_word;
  logic                out_valid;
  logic                out_stall;
  eia_out_t            out_word;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [LimitW-1:0]   cfg_data;

  bit                  tx_gaps_on;
  bit                  rx_gaps_on;
  bit                  long_hold_req;
  alloc_scoreboard     sb;

  entity_id_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic eia_in_t make_cmd(logic op, int id, logic [KindW-1:0] kind);
    eia_in_t w;
    w.op        = op;
    w.entity_id = IdFieldW'(id);
    w.kind      = kind;
    return w;
  endfunction

  // Mostly well-formed traffic: spawns with real kinds and destroys of live
  // identifiers with the kind they were counted under, plus some noise.
  function automatic eia_in_t next_random_word(int spawn_pct);
    eia_in_t w;
    w.op        = OP_SPAWN;
    w.entity_id = IdFieldW'($urandom_range(0, EntitySlots - 1));
    w.kind      = KindW'($urandom_range(1, 3));
    if ($urandom_range(0, 99) < 8) begin
      w.op   = 1'($urandom_range(0, 1));
      w.kind = KindW'($urandom_range(0, 3));
    end else if ($urandom_range(0, 99) >= spawn_pct) begin
      w.op = OP_DESTROY;
      if (sb.live_total != 0 && $urandom_range(0, 9) != 0) begin
        w.entity_id = sb.packed_ids[$urandom_range(0, sb.live_total - 1)];
        if ($urandom_range(0, 9) != 0) begin
          w.kind = sb.born_kind[w.entity_id];
        end
      end
    end
    return w;
  endfunction

  task automatic push_word(input eia_in_t w);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (sb.awaited.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CfgIdxW-1:0] idx, input logic [LimitW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_limit(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = rx_gaps_on ? $urandom_range(0, 9) : 0;
      if (long_hold_req) begin
        hold = LongHold;
        long_hold_req = 1'b0;
      end
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_word(out_word);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("entity_id_allocator test failed");
    $finish;
  end

  initial begin : stimulus
    int n;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_word       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    tx_gaps_on    = 1'b1;
    rx_gaps_on    = 1'b1;
    long_hold_req = 1'b0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_word(make_cmd(OP_DESTROY, 0, KIND_AGENT));
    push_word(make_cmd(OP_SPAWN, 255, KIND_NONE));
    push_word(make_cmd(OP_SPAWN, 0, KIND_AGENT));
    push_word(make_cmd(OP_SPAWN, 170, KIND_ATTRACTOR));
    push_word(make_cmd(OP_SPAWN, 85, KIND_BOTH));
    push_word(make_cmd(OP_DESTROY, 255, KIND_BOTH));
    push_word(make_cmd(OP_DESTROY, 0, KIND_NONE));
    push_word(make_cmd(OP_DESTROY, 1, KIND_ATTRACTOR));
    push_word(make_cmd(OP_DESTROY, 2, KIND_BOTH));
    push_word(make_cmd(OP_DESTROY, 0, KIND_AGENT));
    push_word(make_cmd(OP_DESTROY, 0, KIND_AGENT));
    push_word(make_cmd(OP_SPAWN, 0, KIND_AGENT));
    push_word(make_cmd(OP_DESTROY, 0, KIND_ATTRACTOR));
    push_word(make_cmd(OP_DESTROY, 0, KIND_AGENT));
    drop_valid();
    settle();

    // With one agent allowed, a second spawn of both kinds counts only the
    // attractor, and a plain agent spawn is refused.
    write_limit(CFG_AGENT_LIMIT, 9'd1);
    push_word(make_cmd(OP_SPAWN, 0, KIND_BOTH));
    push_word(make_cmd(OP_SPAWN, 0, KIND_BOTH));
    push_word(make_cmd(OP_SPAWN, 0, KIND_AGENT));
    push_word(make_cmd(OP_DESTROY, 0, KIND_BOTH));
    push_word(make_cmd(OP_DESTROY, 2, KIND_ATTRACTOR));

    for (int p = 0; p < NumPhases; p++) begin
      drop_valid();
      settle();
      write_limit(CFG_AGENT_LIMIT, LimitW'(PhaseAgentCap[p]));
      write_limit(CFG_ATTRACTOR_LIMIT, LimitW'(PhaseAttractorCap[p]));
      write_limit(CfgIdxW'($urandom_range(CFG_ATTRACTOR_LIMIT + 1, 2 ** CfgIdxW - 1)),
                  LimitW'($urandom_range(0, 2 ** LimitW - 1)));
      for (int i = 0; i < PhaseItems[p]; i++) begin
        if (i % 50 == 0) begin
          tx_gaps_on = ($urandom_range(0, 3) != 0);
          rx_gaps_on = ($urandom_range(0, 3) != 0);
        end
        if (p == 0 && i == 100) begin
          long_hold_req = 1'b1;
        end
        push_word(next_random_word(PhaseSpawnPct[p]));
      end
    end

    drop_valid();
    n = 0;
    while (n < DrainLimit && sb.awaited.size() != 0) begin
      @(posedge clk);
      n++;
    end
    repeat (SettleCycles) @(posedge clk);
    sb.flush_missing();
    if (sb.failures == 0) begin
      $display("entity_id_allocator test passed");
    end else begin
      $display("entity_id_allocator test failed");
    end
    $finish;
  end

endmodule
